// ===== rtl/ptts_pkg.sv =====
package ptts_pkg;

    localparam int TABLE_SLOTS_DEFAULT = 8;
    localparam int MAX_RESULTS = 8;

    typedef enum logic [2:0] {
        OP_TICK    = 3'd0,
        OP_ADD     = 3'd1,
        OP_REMOVE  = 3'd2,
        OP_ENABLE  = 3'd3,
        OP_DISABLE = 3'd4
    } opcode_t;

    typedef enum logic [1:0] {
        KIND_ACK   = 2'd0,
        KIND_FIRED = 2'd1,
        KIND_IDLE  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [2:0]  slot;
        logic [31:0] period;
        logic [7:0]  action_id;
    } cmd_word_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] status;
        logic [2:0] out_slot;
        logic [7:0] fired_action;
        logic       last;
    } rsp_word_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMD,
        S_SHIFT,
        S_SCAN,
        S_DIV,
        S_NONE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture command word, bump counter on tick
        logic exec;      // add / enable / disable / bad slot acknowledge
        logic shift;     // one step of remove compaction
        logic scan_init; // start the walk at slot 0
        logic div_start; // start modulo on current slot
        logic div_step;  // one restoring step
        logic emit_fire; // report current slot, advance
        logic skip;      // advance without report
        logic emit_none; // nothing-fired word
    } ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic is_tick;
        logic is_remove;
        logic shift_done;
        logic scan_done;   // index past count or MAX_RESULTS reached
        logic cand;        // current slot enabled with nonzero action
        logic zero_period;
        logic div_done;
        logic rem_zero;
        logic any_fired;
    } sts_t;

endpackage

// ===== rtl/ptts_datapath.sv =====
module ptts_datapath
    import ptts_pkg::*;
#(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cmd_word_t cmd,
    input  ctl_t      ctl,
    output sts_t      sts,
    output logic      result_valid,
    output rsp_word_t result
);
    localparam int IW = $clog2(TABLE_SLOTS + 1);
    localparam int SW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

    logic [31:0] per_reg [TABLE_SLOTS];
    logic [7:0]  act_reg [TABLE_SLOTS];
    logic [TABLE_SLOTS-1:0] en_reg;
    logic [IW-1:0] count_reg;
    logic [31:0] tick_reg;
    cmd_word_t   cmd_reg;
    logic [IW-1:0] idx_reg;
    logic [3:0]  nfire_reg;
    logic [32:0] rem_reg;
    logic [31:0] quo_reg;
    logic [5:0]  bit_reg;
    logic        res_valid_reg;
    rsp_word_t   res_reg;

    logic [SW-1:0] cur;
    logic [IW-1:0] slot_ext;
    logic          slot_ok;
    logic [32:0]   rem_sh;
    logic [32:0]   rem_sub;
    logic [IW-1:0] top;
    status_t       exec_status;
    logic [2:0]    exec_slot;

    assign cur      = idx_reg[SW-1:0];
    assign slot_ext = IW'(cmd_reg.slot);
    assign slot_ok  = (IW'(cmd_reg.slot) < count_reg) && (32'(cmd_reg.slot) < 32'(TABLE_SLOTS));
    assign top      = count_reg - IW'(1);

    // restoring divide: only remainder matters
    assign rem_sh  = {rem_reg[31:0], quo_reg[31]};
    assign rem_sub = rem_sh - {1'b0, per_reg[cur]};

    assign sts.is_tick     = (cmd_reg.opcode == OP_TICK);
    assign sts.is_remove   = (cmd_reg.opcode == OP_REMOVE) && slot_ok;
    assign sts.shift_done  = (idx_reg + IW'(1) >= count_reg);
    assign sts.scan_done   = (idx_reg >= count_reg) || (nfire_reg == 4'(MAX_RESULTS));
    assign sts.cand        = en_reg[cur] && (act_reg[cur] != 8'd0);
    assign sts.zero_period = (per_reg[cur] == 32'd0);
    assign sts.div_done    = (bit_reg == 6'd0);
    assign sts.rem_zero    = (rem_reg == 33'd0);
    assign sts.any_fired   = (nfire_reg != 4'd0);

    // acknowledge fields for add / enable / disable / bad slot
    always_comb
    begin
        exec_status = ST_OK;
        exec_slot   = 3'd0;
        unique case (cmd_reg.opcode)
            OP_ADD:
            begin
                if (count_reg >= IW'(TABLE_SLOTS))
                    exec_status = ST_FULL;
                else
                    exec_slot = 3'(count_reg);
            end
            OP_REMOVE, OP_ENABLE, OP_DISABLE:
            begin
                if (!slot_ok)
                    exec_status = ST_RANGE;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_SLOTS; i++)
            begin
                per_reg[i] <= '0;
                act_reg[i] <= '0;
            end
            en_reg        <= '0;
            count_reg     <= '0;
            tick_reg      <= '0;
            idx_reg       <= '0;
            nfire_reg     <= '0;
            bit_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= ctl.exec || (ctl.shift && sts.shift_done) ||
                             ctl.emit_fire || ctl.emit_none;
            if (ctl.load)
            begin
                cmd_reg   <= cmd;
                idx_reg   <= IW'(cmd.slot);
                nfire_reg <= '0;
                if (cmd.opcode == OP_TICK)
                    tick_reg <= tick_reg + 32'd1;
            end
            if (ctl.exec)
            begin
                res_reg <= '{kind: KIND_ACK, status: exec_status, out_slot: exec_slot,
                             fired_action: 8'd0, last: 1'b1};
                unique case (cmd_reg.opcode)
                    OP_ADD:
                    begin
                        if (count_reg < IW'(TABLE_SLOTS))
                        begin
                            per_reg[count_reg[SW-1:0]] <= cmd_reg.period;
                            act_reg[count_reg[SW-1:0]] <= cmd_reg.action_id;
                            en_reg[count_reg[SW-1:0]]  <= 1'b1;
                            count_reg <= count_reg + IW'(1);
                        end
                    end
                    OP_ENABLE, OP_DISABLE:
                    begin
                        if (slot_ok)
                            en_reg[slot_ext[SW-1:0]] <= (cmd_reg.opcode == OP_ENABLE);
                    end
                    default: ;
                endcase
            end
            if (ctl.shift)
            begin
                if (sts.shift_done)
                begin
                    per_reg[top[SW-1:0]] <= '0;
                    act_reg[top[SW-1:0]] <= '0;
                    en_reg[top[SW-1:0]]  <= 1'b0;
                    count_reg <= top;
                    res_reg <= '{kind: KIND_ACK, status: ST_OK, out_slot: 3'd0,
                                 fired_action: 8'd0, last: 1'b1};
                end
                else
                begin
                    per_reg[cur] <= per_reg[SW'(idx_reg + IW'(1))];
                    act_reg[cur] <= act_reg[SW'(idx_reg + IW'(1))];
                    en_reg[cur]  <= en_reg[SW'(idx_reg + IW'(1))];
                    idx_reg <= idx_reg + IW'(1);
                end
            end
            if (ctl.scan_init)
                idx_reg <= '0;
            if (ctl.div_start)
            begin
                rem_reg <= '0;
                quo_reg <= tick_reg;
                bit_reg <= 6'd32;
            end
            if (ctl.div_step)
            begin
                if (!rem_sub[32])
                    rem_reg <= rem_sub;
                else
                    rem_reg <= rem_sh;
                quo_reg <= {quo_reg[30:0], 1'b0};
                bit_reg <= bit_reg - 6'd1;
            end
            if (ctl.emit_fire)
            begin
                // last is set later if this turns out to be the final fired slot
                res_reg <= '{kind: KIND_FIRED, status: ST_OK, out_slot: 3'(idx_reg),
                             fired_action: act_reg[cur], last: 1'b0};
                nfire_reg <= nfire_reg + 4'd1;
                idx_reg <= idx_reg + IW'(1);
            end
            if (ctl.skip)
                idx_reg <= idx_reg + IW'(1);
            if (ctl.emit_none)
            begin
                res_reg <= '{kind: KIND_IDLE, status: ST_OK, out_slot: 3'd0,
                             fired_action: 8'd0, last: 1'b1};
            end
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

// ===== rtl/ptts_ctrl.sv =====
module ptts_ctrl
    import ptts_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  sts_t sts,
    output ctl_t ctl
);
    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (start) state_next = S_CMD;
            S_CMD:
            begin
                priority if (sts.is_tick)   state_next = S_SCAN;
                else if (sts.is_remove)     state_next = S_SHIFT;
                else                        state_next = S_IDLE;
            end
            S_SHIFT: if (sts.shift_done) state_next = S_IDLE;
            S_SCAN:
            begin
                priority if (sts.scan_done)
                    state_next = sts.any_fired ? S_IDLE : S_NONE;
                else if (sts.cand && !sts.zero_period)
                    state_next = S_DIV;
            end
            S_DIV:   if (sts.div_done) state_next = S_SCAN;
            S_NONE:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ctl = '0;
        unique case (state_reg)
            S_IDLE:  ctl.load = start;
            S_CMD:
            begin
                ctl.scan_init = sts.is_tick;
                ctl.exec      = !sts.is_tick && !sts.is_remove;
            end
            S_SHIFT: ctl.shift = 1'b1;
            S_SCAN:
            begin
                if (!sts.scan_done)
                begin
                    priority if (!sts.cand)   ctl.skip = 1'b1;
                    else if (sts.zero_period) ctl.emit_fire = 1'b1;
                    else                      ctl.div_start = 1'b1;
                end
            end
            S_DIV:
            begin
                if (!sts.div_done)
                    ctl.div_step = 1'b1;
                else if (sts.rem_zero)
                    ctl.emit_fire = 1'b1;
                else
                    ctl.skip = 1'b1;
            end
            S_NONE:  ctl.emit_none = 1'b1;
            default: ;
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && start) |=> state_reg == S_CMD)
        else $error("start not taken");
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctl.emit_fire, ctl.emit_none, ctl.exec}))
        else $error("two results in one cycle");
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.div_step |-> state_reg == S_DIV)
        else $error("divide step outside divide");

endmodule

// ===== rtl/periodic_task_table_scheduler.sv =====
// A remove shifts the later slots down one at a time; a tick walks the slots and
// divides only where a candidate's period is nonzero; a zero period always fires.
// The 32-step restoring divider limits rate: one item in flight, busy high meanwhile.
// A fired word is held until the next word or tick end, so last marks the final one;
// the receiver cannot stall, each word is valid for exactly one cycle.
// Reset (rst_n low, async) clears the table, count and tick counter.
module periodic_task_table_scheduler
    import ptts_pkg::*;
#(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  cmd_word_t cmd,
    output logic      busy,
    output logic      result_valid,
    output rsp_word_t result
);
    ctl_t      ctl;
    sts_t      sts;
    logic      dp_valid;
    rsp_word_t dp_word;
    logic      core_busy;
    logic      start_ok;
    logic      hold_valid_reg;
    rsp_word_t hold_reg;
    logic      out_valid_reg;
    rsp_word_t out_reg;

    assign start_ok = start && !busy;

    ptts_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_ok),
        .busy  (core_busy),
        .sts   (sts),
        .ctl   (ctl)
    );

    ptts_datapath #(.TABLE_SLOTS(TABLE_SLOTS)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .ctl          (ctl),
        .sts          (sts),
        .result_valid (dp_valid),
        .result       (dp_word)
    );

    // fired words wait one slot; released when next word or end of tick appears
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= dp_valid ? ((dp_word.kind != KIND_FIRED) || hold_valid_reg)
                                      : (hold_valid_reg && !core_busy);
            if (dp_valid && dp_word.kind == KIND_FIRED)
            begin
                if (hold_valid_reg)
                    out_reg <= hold_reg;
                hold_valid_reg <= 1'b1;
                hold_reg       <= dp_word;
            end
            else if (dp_valid)
            begin
                out_reg <= dp_word;
            end
            else if (hold_valid_reg && !core_busy)
            begin
                out_reg <= '{kind: hold_reg.kind, status: hold_reg.status,
                             out_slot: hold_reg.out_slot,
                             fired_action: hold_reg.fired_action, last: 1'b1};
                hold_valid_reg <= 1'b0;
            end
        end
    end

    assign busy         = core_busy || hold_valid_reg || out_valid_reg;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule
